// File: hdl/blmf_pkg.sv
package blmf_pkg;

  // Field widths
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned COL_W     = 9;
  localparam int unsigned SUM_W     = 19;
  localparam int unsigned ROWSUM_W  = 10;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned HALF_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  // Signed coordinate width: covers row + half - 1 and frame sizes up to 4096
  localparam int unsigned CRD_W = 14;

  // Default table geometry
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  // Register reset values
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(480);
  localparam logic [HALF_W-1:0] HALF_ROWS_RST    = HALF_W'(12);
  localparam logic [HALF_W-1:0] HALF_COLS_RST    = HALF_W'(12);

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HALF_ROWS    = 2'd2,
    CFG_HALF_COLS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_WIN,
    ST_Q_RD,
    ST_Q_LAST,
    ST_Q_OUT
  } state_e;

  // Corner terms of the summed-area lookup, in read order
  typedef enum logic [1:0] {
    TERM_A = 2'd0,  // (r1, c1)      added
    TERM_B = 2'd1,  // (r0-1, c1)    subtracted
    TERM_D = 2'd2,  // (r1, c0-1)    subtracted
    TERM_E = 2'd3   // (r0-1, c0-1)  added
  } term_e;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [HALF_W-1:0] half_rows;
    logic [HALF_W-1:0] half_cols;
  } cfg_t;

  // Clipped window, bounds inclusive
  typedef struct packed {
    logic             valid;
    crd_t             r0;
    crd_t             r1;
    crd_t             c0;
    crd_t             c1;
    logic [SUM_W-1:0] cells;
  } win_t;

  // Frame size limited to the table geometry
  function automatic crd_t clamp_size(logic [SIZE_W-1:0] v, int unsigned lim);
    crd_t vs;
    crd_t ls;
    vs = crd_t'(v);
    ls = crd_t'(lim);
    return (vs > ls) ? ls : vs;
  endfunction

endpackage

// File: hdl/blmf_if.sv
// Pixel command channel
interface blmf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [8:0] pixel_row;
  logic [8:0] pixel_col;
  logic       label_bit;

  modport source (output valid, command, pixel_row, pixel_col, label_bit, input ready);
  modport sink   (input valid, command, pixel_row, pixel_col, label_bit, output ready);
endinterface

// Filter result channel
interface blmf_out_if;
  logic        valid;
  logic        ready;
  logic        filtered_label;
  logic [18:0] ones_in_window;
  logic [18:0] cells_in_window;

  modport source (output valid, filtered_label, ones_in_window, cells_in_window,
                  input ready);
  modport sink   (input valid, filtered_label, ones_in_window, cells_in_window,
                  output ready);
endinterface

// Register write channel
interface blmf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/blmf_window.sv
// Clips the query window to the frame and counts its cells.
// Bounds are registered on start_i, the cell count in the cycle after.
module blmf_window #(
  parameter int unsigned MAX_WIDTH  = blmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = blmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [blmf_pkg::ROW_W-1:0]  row_i,
  input  logic [blmf_pkg::COL_W-1:0]  col_i,
  input  blmf_pkg::cfg_t              cfg_i,
  output blmf_pkg::win_t              win_o
);

  blmf_pkg::crd_t h_eff, w_eff, rs, cs, hr, hc;
  blmf_pkg::crd_t r0_d, r1_d, c0_d, c1_d;
  blmf_pkg::crd_t r0_q, r1_q, c0_q, c1_q;
  blmf_pkg::crd_t dr, dc;
  logic           valid_d, valid_q;
  logic [2*blmf_pkg::CRD_W-1:0] prod;
  logic [blmf_pkg::SUM_W-1:0]   cells_q;

  // Clip against the frame
  always_comb begin
    h_eff = blmf_pkg::clamp_size(cfg_i.frame_height, MAX_HEIGHT);
    w_eff = blmf_pkg::clamp_size(cfg_i.frame_width, MAX_WIDTH);
    rs    = blmf_pkg::crd_t'(row_i);
    cs    = blmf_pkg::crd_t'(col_i);
    hr    = blmf_pkg::crd_t'(cfg_i.half_rows);
    hc    = blmf_pkg::crd_t'(cfg_i.half_cols);

    r0_d = rs - hr;
    c0_d = cs - hc;
    r1_d = rs + hr - blmf_pkg::crd_t'(1);
    c1_d = cs + hc - blmf_pkg::crd_t'(1);
    if (r0_d < blmf_pkg::crd_t'(0)) r0_d = '0;
    if (c0_d < blmf_pkg::crd_t'(0)) c0_d = '0;
    if (r1_d > h_eff - blmf_pkg::crd_t'(1)) r1_d = h_eff - blmf_pkg::crd_t'(1);
    if (c1_d > w_eff - blmf_pkg::crd_t'(1)) c1_d = w_eff - blmf_pkg::crd_t'(1);

    valid_d = (cfg_i.half_rows != '0) && (cfg_i.half_cols != '0) &&
              (h_eff > blmf_pkg::crd_t'(0)) && (w_eff > blmf_pkg::crd_t'(0)) &&
              (r0_d <= r1_d) && (c0_d <= c1_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (start_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
      c0_q <= c0_d;
      c1_q <= c1_d;
    end
  end

  // Cell count from the registered bounds
  always_comb begin
    dr   = r1_q - r0_q + blmf_pkg::crd_t'(1);
    dc   = c1_q - c0_q + blmf_pkg::crd_t'(1);
    prod = $unsigned(dr) * $unsigned(dc);
  end

  always_ff @(posedge clk_i) begin
    cells_q <= valid_q ? prod[blmf_pkg::SUM_W-1:0] : '0;
  end

  assign win_o.valid = valid_q;
  assign win_o.r0    = r0_q;
  assign win_o.r1    = r1_q;
  assign win_o.c0    = c0_q;
  assign win_o.c1    = c1_q;
  assign win_o.cells = cells_q;

endmodule

// File: hdl/binary_label_majority_filter.sv
// Load word: accept, table read of the entry above, then write back;
// a load outside the frame is dropped in its accept cycle.
// Query word: accept, window check, corner reads, a final step to fold in the last
// read, then the result load; up to four corner reads share the single table port,
// one per cycle. An empty window skips the reads and goes straight to the result.
// A result not yet taken stalls the next query. Reset: control, row sum, registers.
module binary_label_majority_filter #(
  parameter int unsigned MAX_WIDTH  = blmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = blmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blmf_in_if.sink     in_i,
  blmf_out_if.source  out_o,
  blmf_cfg_if.sink    cfg_i
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  localparam int unsigned SUM_W = blmf_pkg::SUM_W;

  // Table address from row and column
  function automatic logic [AW-1:0] addr_of(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  blmf_pkg::state_e state_q, state_d;
  blmf_pkg::term_e  term_q, term_d;
  blmf_pkg::cfg_t   cfg_q;
  blmf_pkg::win_t   win;
  blmf_pkg::crd_t   h_eff, w_eff;

  logic [blmf_pkg::ROWSUM_W-1:0] row_sum_q, row_sum_d;
  logic [blmf_pkg::ROW_W-1:0]    ld_row_q;
  logic [blmf_pkg::COL_W-1:0]    ld_col_q;
  logic [SUM_W-1:0]              acc_q, acc_d;
  logic                          pend_q, pend_d;
  logic                          pend_neg_q, pend_neg_d;

  logic                          in_acc, in_frame, q_start;
  logic                          mem_re, mem_we;
  logic [AW-1:0]                 mem_addr;
  logic [SUM_W-1:0]              mem_wdata, mem_rdata_q;
  logic [SUM_W-1:0]              mem [DEPTH];

  logic                          out_valid_q, out_load;
  logic                          out_label_q;
  logic [SUM_W-1:0]              out_ones_q, out_cells_q;

  // Register write port, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= blmf_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height <= blmf_pkg::FRAME_HEIGHT_RST;
      cfg_q.half_rows    <= blmf_pkg::HALF_ROWS_RST;
      cfg_q.half_cols    <= blmf_pkg::HALF_COLS_RST;
    end else if (cfg_i.valid) begin
      unique case (blmf_pkg::cfg_idx_e'(cfg_i.index))
        blmf_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_i.data;
        blmf_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_i.data;
        blmf_pkg::CFG_HALF_ROWS:    cfg_q.half_rows    <= cfg_i.data[blmf_pkg::HALF_W-1:0];
        blmf_pkg::CFG_HALF_COLS:    cfg_q.half_cols    <= cfg_i.data[blmf_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake and frame check for loads
  assign in_i.ready = (state_q == blmf_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign h_eff      = blmf_pkg::clamp_size(cfg_q.frame_height, MAX_HEIGHT);
  assign w_eff      = blmf_pkg::clamp_size(cfg_q.frame_width, MAX_WIDTH);
  assign in_frame   = (blmf_pkg::crd_t'(in_i.pixel_row) < h_eff) &&
                      (blmf_pkg::crd_t'(in_i.pixel_col) < w_eff);
  assign q_start    = in_acc && (in_i.command == blmf_pkg::CMD_QUERY);

  blmf_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (q_start),
    .row_i   (in_i.pixel_row),
    .col_i   (in_i.pixel_col),
    .cfg_i   (cfg_q),
    .win_o   (win)
  );

  // Sequencer: next state, table access, accumulation
  always_comb begin
    state_d    = state_q;
    term_d     = term_q;
    row_sum_d  = row_sum_q;
    acc_d      = acc_q;
    pend_d     = 1'b0;
    pend_neg_d = pend_neg_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = addr_of(RW'(ld_row_q), CW'(ld_col_q));
    mem_wdata  = SUM_W'(row_sum_q) + ((ld_row_q != '0) ? mem_rdata_q : '0);
    out_load   = 1'b0;

    // fold in the corner read issued last cycle
    if (pend_q) begin
      acc_d = pend_neg_q ? (acc_q - mem_rdata_q) : (acc_q + mem_rdata_q);
    end

    unique case (state_q)
      blmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.command == blmf_pkg::CMD_QUERY) begin
            state_d = blmf_pkg::ST_Q_WIN;
          end else if (in_frame) begin
            row_sum_d = (in_i.pixel_col == '0) ?
                        blmf_pkg::ROWSUM_W'(in_i.label_bit) :
                        row_sum_q + blmf_pkg::ROWSUM_W'(in_i.label_bit);
            state_d   = blmf_pkg::ST_LD_RD;
          end
        end
      end

      blmf_pkg::ST_LD_RD: begin
        mem_re   = (ld_row_q != '0);
        mem_addr = addr_of(RW'(ld_row_q - 1'b1), CW'(ld_col_q));
        state_d  = blmf_pkg::ST_LD_WR;
      end

      blmf_pkg::ST_LD_WR: begin
        mem_we  = 1'b1;
        state_d = blmf_pkg::ST_IDLE;
      end

      blmf_pkg::ST_Q_WIN: begin
        acc_d   = '0;
        term_d  = blmf_pkg::TERM_A;
        state_d = win.valid ? blmf_pkg::ST_Q_RD : blmf_pkg::ST_Q_OUT;
      end

      blmf_pkg::ST_Q_RD: begin
        unique case (term_q)
          blmf_pkg::TERM_A: begin
            mem_re     = 1'b1;
            pend_neg_d = 1'b0;
            mem_addr   = addr_of(RW'(win.r1), CW'(win.c1));
            term_d     = blmf_pkg::TERM_B;
          end
          blmf_pkg::TERM_B: begin
            mem_re     = (win.r0 != '0);
            pend_neg_d = 1'b1;
            mem_addr   = addr_of(RW'(win.r0 - blmf_pkg::crd_t'(1)), CW'(win.c1));
            term_d     = blmf_pkg::TERM_D;
          end
          blmf_pkg::TERM_D: begin
            mem_re     = (win.c0 != '0);
            pend_neg_d = 1'b1;
            mem_addr   = addr_of(RW'(win.r1), CW'(win.c0 - blmf_pkg::crd_t'(1)));
            term_d     = blmf_pkg::TERM_E;
          end
          blmf_pkg::TERM_E: begin
            mem_re     = (win.r0 != '0) && (win.c0 != '0);
            pend_neg_d = 1'b0;
            mem_addr   = addr_of(RW'(win.r0 - blmf_pkg::crd_t'(1)),
                                 CW'(win.c0 - blmf_pkg::crd_t'(1)));
            state_d    = blmf_pkg::ST_Q_LAST;
          end
          default: ;
        endcase
        pend_d = mem_re;
      end

      blmf_pkg::ST_Q_LAST: begin
        state_d = blmf_pkg::ST_Q_OUT;
      end

      blmf_pkg::ST_Q_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = blmf_pkg::ST_IDLE;
        end
      end

      default: state_d = blmf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= blmf_pkg::ST_IDLE;
      term_q     <= blmf_pkg::TERM_A;
      row_sum_q  <= '0;
      pend_q     <= 1'b0;
      pend_neg_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      term_q     <= term_d;
      row_sum_q  <= row_sum_d;
      pend_q     <= pend_d;
      pend_neg_q <= pend_neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      ld_row_q <= in_i.pixel_row;
      ld_col_q <= in_i.pixel_col;
    end
  end

  // Summed-area table, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ones_q  <= acc_q;
      out_cells_q <= win.cells;
      out_label_q <= ({acc_q, 1'b0} > {1'b0, win.cells});
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_label  = out_label_q;
  assign out_o.ones_in_window  = out_ones_q;
  assign out_o.cells_in_window = out_cells_q;

endmodule

// File: sim/tb_binary_label_majority_filter.sv
module tb_binary_label_majority_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import blmf_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1050;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned TABLE_CELLS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    cmd_e             command;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic             label_bit;
  } pix_word_t;

  typedef struct packed {
    logic             label;
    logic [SUM_W-1:0] ones;
    logic [SUM_W-1:0] cells;
  } vote_t;

  // Mirror of the summed-area table and the window vote it feeds
  class majority_predictor;
    bit [SUM_W-1:0]    sat_mem [TABLE_CELLS];
    bit                written [TABLE_CELLS];
    bit [ROWSUM_W-1:0] row_sum;
    cfg_t              regs;
    vote_t             pending_votes [$];
    int unsigned       mismatches, matched, loads_kept, loads_dropped, queries;

    function new();
      regs = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, HALF_ROWS_RST, HALF_COLS_RST};
      row_sum = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  regs.frame_width = v;
        CFG_FRAME_HEIGHT: regs.frame_height = v;
        CFG_HALF_ROWS:    regs.half_rows = v[HALF_W-1:0];
        CFG_HALF_COLS:    regs.half_cols = v[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    function int cols();
      return (regs.frame_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(regs.frame_width);
    endfunction

    function int rows();
      return (regs.frame_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(regs.frame_height);
    endfunction

    function bit in_frame(int r, int c);
      return r < rows() && c < cols();
    endfunction

    // negative coordinates read as zero and never touch the table
    function bit known(int r, int c);
      if (r < 0 || c < 0) return 1'b1;
      return written[r * MAX_WIDTH_DEF + c];
    endfunction

    function bit [SUM_W-1:0] sat_at(int r, int c);
      if (r < 0 || c < 0) return '0;
      return sat_mem[r * MAX_WIDTH_DEF + c];
    endfunction

    // clipped window, inclusive bounds; returns 0 when nothing is left
    function bit clip(int r, int c, output int r0, output int r1,
                      output int c0, output int c1);
      int hr, hc;
      hr = regs.half_rows;
      hc = regs.half_cols;
      r0 = (r - hr < 0) ? 0 : r - hr;
      c0 = (c - hc < 0) ? 0 : c - hc;
      r1 = (r + hr - 1 > rows() - 1) ? rows() - 1 : r + hr - 1;
      c1 = (c + hc - 1 > cols() - 1) ? cols() - 1 : c + hc - 1;
      return hr > 0 && hc > 0 && rows() > 0 && cols() > 0 && r0 <= r1 && c0 <= c1;
    endfunction

    function bit load_safe(int r, int c);
      return !in_frame(r, c) || known(r - 1, c);
    endfunction

    function bit query_safe(int r, int c);
      int r0, r1, c0, c1;
      if (!clip(r, c, r0, r1, c0, c1)) return 1'b1;
      return known(r1, c1) && known(r0 - 1, c1) && known(r1, c0 - 1) &&
             known(r0 - 1, c0 - 1);
    endfunction

    // accepted input word: update the table or queue the expected vote
    function void take_word(pix_word_t w);
      int r, c, r0, r1, c0, c1, idx;
      vote_t v;
      r = int'(w.pixel_row);
      c = int'(w.pixel_col);
      if (w.command == CMD_LOAD) begin
        if (!in_frame(r, c)) begin
          loads_dropped++;
          return;
        end
        if (c == 0) row_sum = ROWSUM_W'(w.label_bit);
        else row_sum = row_sum + ROWSUM_W'(w.label_bit);
        idx = r * MAX_WIDTH_DEF + c;
        sat_mem[idx] = SUM_W'(row_sum) + sat_at(r - 1, c);
        written[idx] = 1'b1;
        loads_kept++;
      end else begin
        v = '0;
        if (clip(r, c, r0, r1, c0, c1)) begin
          v.ones = sat_at(r1, c1) - sat_at(r0 - 1, c1) - sat_at(r1, c0 - 1) +
                   sat_at(r0 - 1, c0 - 1);
          v.cells = SUM_W'((r1 - r0 + 1) * (c1 - c0 + 1));
          v.label = (2 * int'(v.ones) > int'(v.cells));
        end
        pending_votes = {pending_votes, v};
        queries++;
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_vote(vote_t got);
      vote_t exp;
      int unsigned before_errs;
      if (pending_votes.size() == 0) begin
        report_mismatch($sformatf("result with no query waiting (%p)", got));
        return;
      end
      exp = pending_votes.pop_front();
      before_errs = mismatches;
      if (got.label !== exp.label)
        report_mismatch($sformatf("filtered_label %b, want %b", got.label, exp.label));
      if (got.ones !== exp.ones)
        report_mismatch($sformatf("ones_in_window %0d, want %0d", got.ones, exp.ones));
      if (got.cells !== exp.cells)
        report_mismatch($sformatf("cells_in_window %0d, want %0d", got.cells, exp.cells));
      if (mismatches == before_errs) matched++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  blmf_in_if  in_if ();
  blmf_out_if out_if ();
  blmf_cfg_if cfg_if ();

  binary_label_majority_filter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  majority_predictor votes = new();

  int unsigned src_idle_pct = 36;
  int unsigned sink_idle_pct = 75;
  int unsigned hold_cycles = 0;
  int unsigned rand_words = 0;
  int unsigned settings = 0;
  bit          random_phase = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", votes.pending_votes.size());
    $display("== FAIL ==");
    $finish;
  end

  // Result sink: random stalls, long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        votes.check_vote('{out_if.filtered_label, out_if.ones_in_window,
                           out_if.cells_in_window});
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Write all four registers back to back; valid stays high between words
  task automatic program_regs(input int fw, input int fh, input int hr, input int hc);
    cfg_idx_e             order [4] = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT,
                                        CFG_HALF_ROWS, CFG_HALF_COLS};
    logic [CFG_DAT_W-1:0] vals [4];
    vals = '{CFG_DAT_W'(fw), CFG_DAT_W'(fh), CFG_DAT_W'(hr), CFG_DAT_W'(hc)};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[i];
      cfg_if.data  <= vals[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      votes.set_reg(order[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // Offer one pixel word; returns at the accepting edge with valid still high
  task automatic push_word(input cmd_e cmd, input int r, input int c, input bit lbl);
    pix_word_t   w;
    int unsigned gap;
    if (random_phase) begin
      if (rand_words < RANDOM_WORDS / 3) begin
        src_idle_pct = 36;
        sink_idle_pct = 75;
      end else if (rand_words < 2 * RANDOM_WORDS / 3) begin
        src_idle_pct = 75;
        sink_idle_pct = 36;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (cmd == CMD_QUERY || votes.in_frame(r, c)) rand_words++;
    end
    w = '{cmd, ROW_W'(r), COL_W'(c), lbl};
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= w.command;
    in_if.pixel_row <= w.pixel_row;
    in_if.pixel_col <= w.pixel_col;
    in_if.label_bit <= w.label_bit;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    votes.take_word(w);
  endtask

  // Query somewhere in the box whose corner reads are all defined
  task automatic push_query_in(input int rlo, input int rhi, input int clo, input int chi);
    int r, c;
    for (int t = 0; t < 16; t++) begin
      r = $urandom_range(rlo, rhi);
      c = $urandom_range(clo, chi);
      if (votes.query_safe(r, c)) begin
        push_word(CMD_QUERY, r, c, $urandom_range(1));
        return;
      end
    end
  endtask

  // Stray word: query anywhere, or a load anywhere / out of raster order
  task automatic push_noise();
    int r, c;
    if ($urandom_range(1)) begin
      push_query_in(0, 511, 0, 511);
    end else begin
      r = $urandom_range(511);
      c = $urandom_range(511);
      if ($urandom_range(1) && votes.rows() > 0 && votes.cols() > 0) begin
        r = $urandom_range(votes.rows() - 1);
        c = $urandom_range(votes.cols() - 1);
      end
      if (votes.load_safe(r, c)) push_word(CMD_LOAD, r, c, $urandom_range(1));
    end
  endtask

  // Drain: wait for every vote, then let trailing loads finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (votes.pending_votes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_size();
    return ($urandom_range(11) == 0) ? 0 : int'($urandom_range(1, 12));
  endfunction

  function automatic int pick_half();
    case ($urandom_range(9))
      0: return 0;
      1: return 255;
      default: return int'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic directed_checks();
    // two-row strip at the far right edge, sparse and out of raster order
    program_regs(1023, 2, 1, 1);
    push_word(CMD_LOAD, 0, 511, 1'b1);
    push_word(CMD_LOAD, 0, 510, 1'b1);
    push_word(CMD_LOAD, 0, 509, 1'b0);
    push_word(CMD_LOAD, 0, 255, 1'b1);
    push_word(CMD_LOAD, 0, 0, 1'b1);
    push_word(CMD_LOAD, 1, 511, 1'b1);
    push_word(CMD_LOAD, 1, 510, 1'b0);
    push_word(CMD_LOAD, 1, 509, 1'b1);
    push_word(CMD_LOAD, 1, 255, 1'b1);
    push_word(CMD_LOAD, 1, 0, 1'b0);
    push_word(CMD_LOAD, 511, 511, 1'b1);   // below the frame: dropped
    push_word(CMD_QUERY, 1, 511, 1'b0);
    push_word(CMD_QUERY, 0, 0, 1'b1);
    push_word(CMD_QUERY, 2, 511, 1'b0);    // centre outside, window still overlaps
    push_word(CMD_QUERY, 511, 511, 1'b1);  // window misses the frame
    settle();
    // widest half sizes
    program_regs(1023, 2, 255, 255);
    push_word(CMD_QUERY, 0, 511, 1'b0);
    push_word(CMD_QUERY, 511, 0, 1'b0);
    settle();
    // zero frame width
    program_regs(0, 1023, 1, 1);
    push_word(CMD_LOAD, 0, 0, 1'b1);
    push_word(CMD_QUERY, 0, 0, 1'b0);
    settle();
    // zero half height
    program_regs(512, 1, 0, 3);
    push_word(CMD_QUERY, 0, 1, 1'b0);
    settle();
    // zero frame height, zero half width
    program_regs(512, 0, 1, 0);
    push_word(CMD_LOAD, 0, 5, 1'b1);
    push_word(CMD_QUERY, 0, 0, 1'b0);
    settle();
  endtask

  // Small frame loaded in raster order, then a burst of queries around it
  task automatic small_frame(input bit squeeze);
    int fw, fh, hr, hc, rw, rh, density, rhi, chi;
    fw = pick_size();
    fh = pick_size();
    hr = pick_half();
    hc = pick_half();
    if (squeeze) begin
      fw = 6;
      fh = 5;
      hr = 2;
      hc = 2;
    end
    program_regs(fw, fh, hr, hc);
    rw = votes.cols();
    rh = votes.rows();
    density = $urandom_range(100);
    for (int r = 0; r < rh; r++) begin
      for (int c = 0; c < rw; c++) begin
        if ($urandom_range(99) < 6) push_noise();
        push_word(CMD_LOAD, r, c, $urandom_range(99) < density);
      end
    end
    // receiver goes quiet while queries keep coming
    if (squeeze) hold_cycles = SQUEEZE_CYCLES;
    rhi = (rh - 1 + hr > 511) ? 511 : ((rh - 1 + hr < 0) ? 0 : rh - 1 + hr);
    chi = (rw - 1 + hc > 511) ? 511 : ((rw - 1 + hc < 0) ? 0 : rw - 1 + hc);
    repeat (rw * rh / 3 + 4) begin
      if ($urandom_range(9) == 0) push_query_in(0, 511, 0, 511);
      else push_query_in(0, rhi, 0, chi);
    end
    settle();
  endtask

  // One column the full table height: reaches the top row addresses
  task automatic tall_column();
    int density;
    program_regs(1, 512, $urandom_range(1, 3), $urandom_range(1, 2));
    density = $urandom_range(100);
    for (int r = 0; r < MAX_HEIGHT_DEF; r++) begin
      if ($urandom_range(15) == 0) density = $urandom_range(100);
      if ($urandom_range(99) < 3) push_noise();
      push_word(CMD_LOAD, r, 0, $urandom_range(99) < density);
    end
    repeat (40) push_query_in(0, 511, 0, 3);
    settle();
  endtask

  task automatic random_traffic();
    int frame_no;
    bit tall_done;
    frame_no = 0;
    tall_done = 1'b0;
    random_phase = 1'b1;
    while (rand_words < RANDOM_WORDS) begin
      if (!tall_done && rand_words >= 300) begin
        tall_column();
        tall_done = 1'b1;
      end else begin
        small_frame(frame_no == 0);
        frame_no++;
      end
    end
  endtask

  // Stimulus
  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.command   <= CMD_LOAD;
    in_if.pixel_row <= '0;
    in_if.pixel_col <= '0;
    in_if.label_bit <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_FRAME_WIDTH;
    cfg_if.data     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();
    random_traffic();
    settle();

    $display("Ran %0d register settings: %0d loads stored, %0d loads outside the frame,",
             settings, votes.loads_kept, votes.loads_dropped);
    $display("%0d window queries; %0d results matched, %0d mismatches",
             votes.queries, votes.matched, votes.mismatches);
    if (votes.mismatches == 0 && votes.pending_votes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
